>>> hdl/bdgc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Bayer demosaic block.
// No dependencies; the top level, bdgc_regs, bdgc_seq, bdgc_lstore and bdgc_kern import this package.
package bdgc_pkg;

    localparam int C_MAX_WIDTH   = 4096;
    localparam int C_SAMPLE_BITS = 16;
    localparam int C_WIN         = 5;
    localparam int C_RING_ROWS   = 6;
    localparam int C_ADDR_BITS   = 4;
    localparam int C_DATA_BITS   = 32;

    localparam logic        C_CFA_RESET    = 1'b0;
    localparam logic [12:0] C_WIDTH_RESET  = 13'd4096;
    localparam logic [15:0] C_HEIGHT_RESET = 16'd2;

    typedef enum logic [1:0] {
        REG_CFA_PATTERN  = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } t_reg_idx;

    typedef logic [2:0] t_bank;
    typedef logic [2:0] t_tap;

    typedef struct packed {
        logic        cfa;
        logic [12:0] width;
        logic [15:0] height;
    } t_cfg;

    // Per-beat control that travels with the column read.
    typedef struct packed {
        logic                   has_out;
        logic                   r_odd;
        logic                   c_odd;
        logic                   last;
        logic                   pat;
        t_tap  [C_WIN-1:0]      col_tap;
        t_bank [C_WIN-1:0]      row_bank;
        logic  [C_WIN-1:0]      row_byp;
    } t_item;

    // Step a ring row index back by off rows, modulo the ring size.
    function automatic t_bank bank_back(t_bank b, logic [2:0] off);
        logic [3:0] s;
        s = {1'b0, b} + 4'(C_RING_ROWS) - {1'b0, off};
        if (s >= 4'(C_RING_ROWS)) begin
            s = s - 4'(C_RING_ROWS);
        end
        return s[2:0];
    endfunction

endpackage

>>> hdl/bdgc_if.sv
`timescale 1ns / 1ps
// Stream interfaces for raw Bayer samples in and RGB pixels out.
// No dependencies.
interface bdgc_raw_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_sample;
    logic        flush;
    modport source (output valid, output raw_sample, output flush, input ready);
    modport sink (input valid, input raw_sample, input flush, output ready);
endinterface

interface bdgc_rgb_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        frame_end;
    modport source (output valid, output red, output green, output blue,
                    output frame_end, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input frame_end, output ready);
endinterface

>>> hdl/bayer_demosaic_gradient_corrected_top.sv
`timescale 1ns / 1ps
// Top level of the 5x5 gradient-corrected Bayer demosaic.
// Depends on bdgc_pkg, bdgc_if, bdgc_regs, bdgc_seq, bdgc_lstore, bdgc_kern.
//
// Raw Bayer samples enter in raster order on i_raw, one beat per clock while
// ready is high, and RGB pixels leave on o_rgb at one pixel per clock while
// o_rgb is ready; the sustained rate is one beat per cycle when the output
// does not stall, set by one write and one column read of each line store bank
// per cycle. A beat passes three register stages, in order: the line store
// read, the window history and the output register. A pixel
// is produced once the input runs two rows and two pixels ahead of it, so the
// frame's first 2*width+2 samples give no pixel; after the last sample, send
// flush beats (or further samples, whose values are dropped) to drain the
// last 2*width+2 pixels, the final one carrying frame_end. A flush beat inside
// the frame is taken and dropped. Borders replicate the edge samples. The CFA
// pattern, width and height registers are sampled when a frame's first sample
// is taken, so writes made mid-frame apply from the next frame; width is held
// to 2..MAX_WIDTH and height to at least 2. The line store is six rows of
// MAX_WIDTH samples and needs no clearing pass after reset, since only rows of
// the current frame are ever read. Ready drops only while a finished pixel
// waits on o_rgb and the pipeline behind it is full.
module bayer_demosaic_gradient_corrected_top #(
    parameter int MAX_WIDTH   = bdgc_pkg::C_MAX_WIDTH,
    parameter int SAMPLE_BITS = bdgc_pkg::C_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bdgc_raw_if.sink                            i_raw,
    bdgc_rgb_if.source                          o_rgb,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bdgc_pkg::C_ADDR_BITS-1:0]    paddr,
    input  logic [bdgc_pkg::C_DATA_BITS-1:0]    pwdata,
    output logic [bdgc_pkg::C_DATA_BITS-1:0]    prdata,
    output logic                                pready
);
    import bdgc_pkg::*;

    localparam int C_BITS = $clog2(MAX_WIDTH);

    t_cfg                                   cfg;
    logic                                   accept, go, wr_en, ready1, v1, take1;
    t_bank                                  wr_bank;
    logic [C_BITS-1:0]                      col;
    t_item                                  item0, item1;
    logic [C_WIN-1:0][SAMPLE_BITS-1:0]      vec;

    // A beat is taken whenever the first pipeline stage can move.
    assign i_raw.ready = ready1;
    assign accept      = i_raw.valid && ready1;

    bdgc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Track the input position and plan the column read for each beat.
    bdgc_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_flush   (i_raw.flush),
        .i_cfg     (cfg),
        .o_go      (go),
        .o_wr_en   (wr_en),
        .o_wr_bank (wr_bank),
        .o_col     (col),
        .o_item    (item0)
    );

    // Write the sample and read the five-row column in the same cycle.
    bdgc_lstore #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lstore (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_wr_en   (wr_en),
        .i_wr_bank (wr_bank),
        .i_col     (col),
        .i_sample  (i_raw.raw_sample[SAMPLE_BITS-1:0]),
        .i_item    (item0),
        .i_take    (take1),
        .o_ready   (ready1),
        .o_valid   (v1),
        .o_item    (item1),
        .o_vec     (vec)
    );

    // Shift the column into the history and form the pixel.
    bdgc_kern #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_kern (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .i_item  (item1),
        .i_vec   (vec),
        .o_take  (take1),
        .o_rgb   (o_rgb)
    );

endmodule

>>> hdl/bdgc_regs.sv
`timescale 1ns / 1ps
// APB-style configuration registers: CFA pattern, frame width and height.
// Depends on bdgc_pkg.
module bdgc_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bdgc_pkg::C_ADDR_BITS-1:0]    paddr,
    input  logic [bdgc_pkg::C_DATA_BITS-1:0]    pwdata,
    output logic [bdgc_pkg::C_DATA_BITS-1:0]    prdata,
    output logic                                pready,
    output bdgc_pkg::t_cfg                      o_cfg
);
    import bdgc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cfa    <= C_CFA_RESET;
            r_cfg.width  <= C_WIDTH_RESET;
            r_cfg.height <= C_HEIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_CFA_PATTERN:  r_cfg.cfa    <= pwdata[0];
                REG_FRAME_WIDTH:  r_cfg.width  <= pwdata[12:0];
                REG_FRAME_HEIGHT: r_cfg.height <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CFA_PATTERN:  prdata = {31'd0, r_cfg.cfa};
            REG_FRAME_WIDTH:  prdata = {19'd0, r_cfg.width};
            REG_FRAME_HEIGHT: prdata = {16'd0, r_cfg.height};
            default:          prdata = '0;
        endcase
    end

endmodule

>>> hdl/bdgc_seq.sv
`timescale 1ns / 1ps
// Frame position sequencer: input row/column, frame latching, line store
// addressing and per-beat window control. Depends on bdgc_pkg.
module bdgc_seq #(
    parameter  int MAX_WIDTH = bdgc_pkg::C_MAX_WIDTH,
    localparam int C_BITS    = $clog2(MAX_WIDTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_flush,
    input  bdgc_pkg::t_cfg      i_cfg,
    output logic                o_go,
    output logic                o_wr_en,
    output bdgc_pkg::t_bank     o_wr_bank,
    output logic [C_BITS-1:0]   o_col,
    output bdgc_pkg::t_item     o_item
);
    import bdgc_pkg::*;

    localparam int W_BITS = $clog2(MAX_WIDTH + 1);
    localparam int R_BITS = 17;
    localparam int SPAN   = C_WIN - 1;

    logic [C_BITS-1:0] r_col;
    logic [R_BITS-1:0] r_row;
    t_bank             r_bank;
    logic              r_pat;
    logic [W_BITS-1:0] r_w;
    logic [15:0]       r_h;

    logic              start, pat, in_frame, wrap, row_wrap;
    logic [W_BITS-1:0] cfg_w, w;
    logic [15:0]       cfg_h, h;
    logic [R_BITS-1:0] h_ext, dhi;
    logic [W_BITS:0]   sum_hi;
    logic [2:0]        hi3, lo3, tap, off;
    t_item             item;

    always_comb begin
        if (i_cfg.width < 13'd2) begin
            cfg_w = W_BITS'(2);
        end else if (32'(i_cfg.width) > 32'(MAX_WIDTH)) begin
            cfg_w = W_BITS'(MAX_WIDTH);
        end else begin
            cfg_w = W_BITS'(i_cfg.width);
        end
        cfg_h = (i_cfg.height < 16'd2) ? 16'd2 : i_cfg.height;

        start    = (r_row == '0) && (r_col == '0);
        w        = start ? cfg_w : r_w;
        h        = start ? cfg_h : r_h;
        pat      = start ? i_cfg.cfa : r_pat;
        h_ext    = R_BITS'(h);
        in_frame = r_row < h_ext;
        wrap     = r_col < C_BITS'(2);
        row_wrap = (W_BITS'(r_col) + W_BITS'(1)) == w;
        dhi      = r_row - h_ext + R_BITS'(1);

        item.has_out = !((r_row < R_BITS'(2)) ||
                         ((r_row == R_BITS'(2)) && (r_col < C_BITS'(2))));
        item.r_odd   = r_row[0] ^ wrap;
        item.c_odd   = wrap ? (r_col[0] ^ w[0]) : r_col[0];
        item.last    = (r_col == C_BITS'(1)) && (r_row == h_ext + R_BITS'(2));
        item.pat     = pat;

        // Column taps into the history; clamp at the left and right edges.
        sum_hi = (W_BITS + 1)'(r_col) + (W_BITS + 1)'(w);
        if (wrap) begin
            hi3 = (sum_hi > (W_BITS + 1)'(SPAN)) ? 3'(SPAN) : sum_hi[2:0];
            lo3 = 3'(r_col[0]) + 3'd1;
        end else begin
            hi3 = (r_col > C_BITS'(SPAN)) ? 3'(SPAN) : r_col[2:0];
            lo3 = 3'd0;
        end
        for (int dx = 0; dx < C_WIN; dx++) begin
            tap = 3'(SPAN - dx);
            if (tap > hi3) tap = hi3;
            if (tap < lo3) tap = lo3;
            item.col_tap[dx] = tap;
        end

        // Row banks for the column read; clamp at the top and bottom.
        for (int dy = 0; dy < C_WIN; dy++) begin
            if (r_row + R_BITS'(dy) < R_BITS'(SPAN)) begin
                off = r_row[2:0];
            end else if (r_row + R_BITS'(dy) >= h_ext + R_BITS'(SPAN)) begin
                off = dhi[2:0];
            end else begin
                off = 3'(SPAN - dy);
            end
            item.row_bank[dy] = bank_back(r_bank, off);
            item.row_byp[dy]  = (off == 3'd0) && in_frame;
        end
    end

    assign o_go      = i_accept && !(i_flush && in_frame);
    assign o_wr_en   = o_go && in_frame;
    assign o_wr_bank = r_bank;
    assign o_col     = r_col;
    assign o_item    = item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bank <= '0;
            r_pat  <= C_CFA_RESET;
            r_w    <= W_BITS'(MAX_WIDTH);
            r_h    <= C_HEIGHT_RESET;
        end else if (o_go) begin
            if (start) begin
                r_pat <= i_cfg.cfa;
                r_w   <= cfg_w;
                r_h   <= cfg_h;
            end
            if (item.has_out && item.last) begin
                r_col  <= '0;
                r_row  <= '0;
                r_bank <= '0;
            end else if (row_wrap) begin
                r_col  <= '0;
                r_row  <= r_row + R_BITS'(1);
                r_bank <= (r_bank == t_bank'(C_RING_ROWS - 1)) ? '0 : r_bank + 3'd1;
            end else begin
                r_col <= r_col + C_BITS'(1);
            end
        end
    end

endmodule

>>> hdl/bdgc_lstore.sv
`timescale 1ns / 1ps
// Six-row line store with a registered column read and write bypass.
// Depends on bdgc_pkg.
module bdgc_lstore #(
    parameter  int MAX_WIDTH   = bdgc_pkg::C_MAX_WIDTH,
    parameter  int SAMPLE_BITS = bdgc_pkg::C_SAMPLE_BITS,
    localparam int C_BITS      = $clog2(MAX_WIDTH)
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_go,
    input  logic                                            i_wr_en,
    input  bdgc_pkg::t_bank                                 i_wr_bank,
    input  logic [C_BITS-1:0]                               i_col,
    input  logic [SAMPLE_BITS-1:0]                          i_sample,
    input  bdgc_pkg::t_item                                 i_item,
    input  logic                                            i_take,
    output logic                                            o_ready,
    output logic                                            o_valid,
    output bdgc_pkg::t_item                                 o_item,
    output logic [bdgc_pkg::C_WIN-1:0][SAMPLE_BITS-1:0]     o_vec
);
    import bdgc_pkg::*;

    logic [SAMPLE_BITS-1:0] r_ram [C_RING_ROWS][MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] r_q   [C_RING_ROWS];
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_v1;
    t_item                  r_item;

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < C_RING_ROWS; b++) begin
            if (i_wr_en && (i_wr_bank == t_bank'(b))) begin
                r_ram[b][i_col] <= i_sample;
            end
            if (i_go) begin
                r_q[b] <= r_ram[b][i_col];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_item   <= i_item;
            r_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_go) begin
            r_v1 <= 1'b1;
        end else if (i_take) begin
            r_v1 <= 1'b0;
        end
    end

    always_comb begin
        for (int dy = 0; dy < C_WIN; dy++) begin
            o_vec[dy] = r_item.row_byp[dy] ? r_sample : r_q[r_item.row_bank[dy]];
        end
    end

    assign o_ready = !r_v1 || i_take;
    assign o_valid = r_v1;
    assign o_item  = r_item;

endmodule

>>> hdl/bdgc_kern.sv
`timescale 1ns / 1ps
// Column history, 5x5 window selection, gradient-corrected kernels and the
// output register. Depends on bdgc_pkg and bdgc_if.
module bdgc_kern #(
    parameter int SAMPLE_BITS = bdgc_pkg::C_SAMPLE_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  bdgc_pkg::t_item                             i_item,
    input  logic [bdgc_pkg::C_WIN-1:0][SAMPLE_BITS-1:0] i_vec,
    output logic                                        o_take,
    bdgc_rgb_if.source                                  o_rgb
);
    import bdgc_pkg::*;

    localparam int SW = SAMPLE_BITS + 7;

    logic [C_WIN-1:0][C_WIN-1:0][SAMPLE_BITS-1:0] r_hist;
    logic                   r_v2, r_ov, r_fe;
    t_item                  r_item2;
    logic [15:0]            r_red, r_green, r_blue;

    logic                   en_out, leave2;
    logic [SAMPLE_BITS-1:0] win [C_WIN][C_WIN];
    logic signed [SW-1:0]   c, n1, s1, w1, e1, n2, s2, w2, e2, dg, ax;
    logic signed [SW-1:0]   gsum, opp, hor, ver;
    logic [SAMPLE_BITS-1:0] g_v, o_v, h_v, v_v, red, green, blue;
    logic                   red_row, red_col;

    function automatic logic signed [SW-1:0] ext(logic [SAMPLE_BITS-1:0] x);
        return $signed({7'd0, x});
    endfunction

    // Clamp negatives to zero, scale down, saturate to the sample range.
    function automatic logic [SAMPLE_BITS-1:0] finish(logic signed [SW-1:0] s,
                                                      logic sh4);
        logic [SW-1:0] v;
        v = sh4 ? SW'(s >>> 4) : SW'(s >>> 3);
        if (s < 0) begin
            return '0;
        end else if (v[SW-1:SAMPLE_BITS] != '0) begin
            return '1;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    assign en_out = !r_ov || o_rgb.ready;
    assign leave2 = r_v2 && (!r_item2.has_out || en_out);
    assign o_take = i_valid && (!r_v2 || leave2);

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_hist  <= {r_hist[C_WIN-2:0], i_vec};
            r_item2 <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_take) begin
                r_v2 <= 1'b1;
            end else if (leave2) begin
                r_v2 <= 1'b0;
            end
            if (en_out) begin
                r_ov <= leave2 && r_item2.has_out;
            end
        end
    end

    always_comb begin
        for (int dy = 0; dy < C_WIN; dy++) begin
            for (int dx = 0; dx < C_WIN; dx++) begin
                win[dy][dx] = r_hist[r_item2.col_tap[dx]][dy];
            end
        end
        c  = ext(win[2][2]);
        n1 = ext(win[1][2]);
        s1 = ext(win[3][2]);
        w1 = ext(win[2][1]);
        e1 = ext(win[2][3]);
        n2 = ext(win[0][2]);
        s2 = ext(win[4][2]);
        w2 = ext(win[2][0]);
        e2 = ext(win[2][4]);
        dg = ext(win[1][1]) + ext(win[1][3]) + ext(win[3][1]) + ext(win[3][3]);
        ax = n2 + s2 + w2 + e2;

        gsum = (c <<< 2) + ((n1 + s1 + w1 + e1) <<< 1) - ax;
        opp  = (c <<< 3) + (c <<< 2) + (dg <<< 2) - (ax <<< 1) - ax;
        hor  = (c <<< 3) + (c <<< 1) + ((w1 + e1) <<< 3) + n2 + s2
             - ((w2 + e2 + dg) <<< 1);
        ver  = (c <<< 3) + (c <<< 1) + ((n1 + s1) <<< 3) + w2 + e2
             - ((n2 + s2 + dg) <<< 1);

        g_v = finish(gsum, 1'b0);
        o_v = finish(opp, 1'b1);
        h_v = finish(hor, 1'b1);
        v_v = finish(ver, 1'b1);

        red_row = r_item2.r_odd == r_item2.pat;
        red_col = r_item2.c_odd == r_item2.pat;
        priority if (red_row && red_col) begin
            red = win[2][2]; green = g_v; blue = o_v;
        end else if (!red_row && !red_col) begin
            blue = win[2][2]; green = g_v; red = o_v;
        end else if (red_row) begin
            green = win[2][2]; red = h_v; blue = v_v;
        end else begin
            green = win[2][2]; blue = h_v; red = v_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && leave2 && r_item2.has_out) begin
            r_red   <= 16'(red);
            r_green <= 16'(green);
            r_blue  <= 16'(blue);
            r_fe    <= r_item2.last;
        end
    end

    assign o_rgb.valid     = r_ov;
    assign o_rgb.red       = r_red;
    assign o_rgb.green     = r_green;
    assign o_rgb.blue      = r_blue;
    assign o_rgb.frame_end = r_fe;

endmodule

>>> hdl/bdgc_chk.sv
`timescale 1ns / 1ps
// Port-level checks on the demosaic top level, attached by bind.
// Depends on bayer_demosaic_gradient_corrected_top and bdgc_if.
module bdgc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_red,
    input logic [15:0] i_green,
    input logic [15:0] i_blue,
    input logic        i_frame_end
);

    // A pixel appearing on an empty output must follow an input beat that was taken.
    a_rise_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 3))
        else $error("output pixel without a matching input beat");

    // Backpressure reaches the input only while the output is stalled.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled while output is free");

    // Hold a stalled pixel.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_red) && $stable(i_green) &&
             $stable(i_blue) && $stable(i_frame_end)))
        else $error("stalled output pixel changed");

endmodule

bind bayer_demosaic_gradient_corrected_top bdgc_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_raw.valid),
    .i_in_ready  (i_raw.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue),
    .i_frame_end (o_rgb.frame_end)
);
